### sv/twtt_pkg.sv
`timescale 1ns / 1ps

package twtt_pkg;

    localparam int TIMER_ENTRIES = 16;
    localparam int MAX_WHEEL     = 256;
    localparam int WHEEL_RESET   = 60;

    localparam int ID_W    = 64;
    localparam int DELAY_W = 16;
    localparam int WHEEL_W = 9;
    localparam int ENT_W   = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_REFRESH = 2'd1,
        ACT_CANCEL  = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_QUIET = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUPLICATE = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         action;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay;
    } t_cmd;

    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      status;
        logic [ID_W-1:0] fired_id;
        logic            last;
    } t_result;

endpackage

### sv/twtt_rem.sv
`timescale 1ns / 1ps

module twtt_rem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [twtt_pkg::DELAY_W-1:0]   i_dividend,
    input  logic [twtt_pkg::WHEEL_W-1:0]   i_divisor,
    output logic                           o_busy,
    output logic [twtt_pkg::WHEEL_W-1:0]   o_rem
);
    import twtt_pkg::*;

    localparam int CNT_W = (DELAY_W > 1) ? $clog2(DELAY_W) : 1;

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [WHEEL_W-1:0] r_rem;
    logic [DELAY_W-1:0] r_dvd;
    logic [WHEEL_W-1:0] r_dvs;
    logic [WHEEL_W:0]   trial;
    logic               fits;

    // Restoring division, one dividend bit per cycle, keeping only the remainder.
    assign trial = {r_rem, r_dvd[DELAY_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DELAY_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            if (fits) begin
                r_rem <= WHEEL_W'(trial - {1'b0, r_dvs});
            end else begin
                r_rem <= trial[WHEEL_W-1:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

### sv/timing_wheel_timer_table.sv
`timescale 1ns / 1ps

// Timer table with up to 16 timers keyed by 64-bit id. A command or tick is
// taken when start is high and busy is low; busy then stays high while the
// table is walked one entry per cycle and until a finish state, which waits
// for the divider, completes the command, so no new item is taken before
// then. The remainder of an add's delay is formed by a
// bit-serial divider that runs alongside the walk. Every result beat is shown
// on o_res for exactly one cycle with o_res_valid high and cannot be held
// off; the receiver must take it then. On a tick, fired beats appear during
// the walk and the beat marked last arrives as busy falls. wheel_size may be
// written at any time through i_cfg_we, but only while busy is low is its
// effect defined.
module timing_wheel_timer_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  twtt_pkg::t_cmd                i_cmd,
    input  logic                          i_cfg_we,
    input  logic [twtt_pkg::WHEEL_W-1:0]  i_cfg_wdata,
    output logic                          o_res_valid,
    output twtt_pkg::t_result             o_res
);
    import twtt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [WHEEL_W-1:0]  r_wheel;
    logic [WHEEL_W-1:0]  r_ws;
    t_cmd                r_cmd;
    logic [ENT_W-1:0]    r_idx;
    logic                r_hit;
    logic [ENT_W-1:0]    r_hit_idx;
    logic                r_free;
    logic [ENT_W-1:0]    r_free_idx;
    logic                r_pend;
    logic [ID_W-1:0]     r_pend_id;
    logic                r_res_valid;
    t_result             r_res;

    logic                r_ent_valid  [TIMER_ENTRIES];
    logic [ID_W-1:0]     r_ent_id     [TIMER_ENTRIES];
    logic [WHEEL_W-1:0]  r_ent_delay  [TIMER_ENTRIES];
    logic [WHEEL_W-1:0]  r_ent_rem    [TIMER_ENTRIES];
    logic                r_ent_cancel [TIMER_ENTRIES];

    logic                accept;
    logic [WHEEL_W-1:0]  eff_ws;
    logic                div_busy;
    logic [WHEEL_W-1:0]  div_rem;
    logic [WHEEL_W-1:0]  add_delay;
    logic                is_tick;
    logic                scanning;
    logic                finishing;
    logic                cur_valid;
    logic [WHEEL_W-1:0]  cur_dec;
    logic                cur_expire;
    logic                add_ok;
    logic                cmd_hit_ok;
    t_status             cmd_status;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign is_tick   = (r_cmd.action == ACT_TICK);
    assign scanning  = (r_state == S_SCAN);
    assign finishing = (r_state == S_FINISH) && !div_busy;

    always_comb begin
        if (r_wheel == '0) begin
            eff_ws = WHEEL_W'(1);
        end else if (r_wheel > WHEEL_W'(MAX_WHEEL)) begin
            eff_ws = WHEEL_W'(MAX_WHEEL);
        end else begin
            eff_ws = r_wheel;
        end
    end

    twtt_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (i_cmd.delay),
        .i_divisor  (eff_ws),
        .o_busy     (div_busy),
        .o_rem      (div_rem)
    );

    // A remainder of zero stands for one full turn of the wheel.
    assign add_delay = (div_rem == '0) ? r_ws : div_rem;

    assign cur_valid  = r_ent_valid[r_idx];
    assign cur_dec    = (r_ent_rem[r_idx] != '0) ? r_ent_rem[r_idx] - 1'b1 : '0;
    assign cur_expire = cur_valid && (cur_dec == '0);

    always_comb begin
        add_ok     = 1'b0;
        cmd_hit_ok = 1'b0;
        case (r_cmd.action)
            ACT_ADD: begin
                if (r_hit) begin
                    cmd_status = ST_DUPLICATE;
                end else if (!r_free) begin
                    cmd_status = ST_FULL;
                end else begin
                    cmd_status = ST_OK;
                    add_ok     = finishing;
                end
            end
            ACT_REFRESH, ACT_CANCEL: begin
                cmd_status = r_hit ? ST_OK : ST_NOT_FOUND;
                cmd_hit_ok = finishing && r_hit;
            end
            default: begin
                cmd_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= WHEEL_W'(WHEEL_RESET);
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < TIMER_ENTRIES; i++) begin
                r_ent_valid[i] <= 1'b0;
            end
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_we) begin
                r_wheel <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                        r_cmd   <= i_cmd;
                        r_ws    <= eff_ws;
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_pend  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (is_tick) begin
                        if (cur_expire) begin
                            r_ent_valid[r_idx] <= 1'b0;
                            // Each fired beat is held back one find so that
                            // the final one can carry last.
                            if (!r_ent_cancel[r_idx]) begin
                                if (r_pend) begin
                                    r_res_valid    <= 1'b1;
                                    r_res.kind     <= KIND_FIRED;
                                    r_res.status   <= ST_OK;
                                    r_res.fired_id <= r_pend_id;
                                    r_res.last     <= 1'b0;
                                end
                                r_pend    <= 1'b1;
                                r_pend_id <= r_ent_id[r_idx];
                            end
                        end
                    end else begin
                        if (cur_valid && !r_hit && (r_ent_id[r_idx] == r_cmd.timer_id)) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_idx;
                        end
                        if (!cur_valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_idx;
                        end
                    end
                    if (r_idx == ENT_W'(TIMER_ENTRIES - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (!div_busy) begin
                        r_state     <= S_IDLE;
                        r_res_valid <= 1'b1;
                        r_res.last  <= 1'b1;
                        if (is_tick) begin
                            r_res.status <= ST_OK;
                            if (r_pend) begin
                                r_res.kind     <= KIND_FIRED;
                                r_res.fired_id <= r_pend_id;
                            end else begin
                                r_res.kind     <= KIND_QUIET;
                                r_res.fired_id <= '0;
                            end
                        end else begin
                            r_res.kind     <= KIND_ACK;
                            r_res.status   <= cmd_status;
                            r_res.fired_id <= r_cmd.timer_id;
                            if (add_ok) begin
                                r_ent_valid[r_free_idx] <= 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (scanning && is_tick && cur_valid) begin
            r_ent_rem[r_idx] <= cur_dec;
        end
        if (add_ok) begin
            r_ent_id[r_free_idx]     <= r_cmd.timer_id;
            r_ent_delay[r_free_idx]  <= add_delay;
            r_ent_rem[r_free_idx]    <= add_delay;
            r_ent_cancel[r_free_idx] <= 1'b0;
        end
        if (cmd_hit_ok) begin
            if (r_cmd.action == ACT_REFRESH) begin
                r_ent_rem[r_hit_idx] <= r_ent_delay[r_hit_idx];
            end else begin
                r_ent_cancel[r_hit_idx] <= 1'b1;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import twtt_pkg::*;

    localparam int POOL_SIZE = 20;

    typedef enum logic {
        STEP_COMMAND,
        STEP_SET_WHEEL
    } t_step_kind;

    typedef struct {
        t_step_kind         kind;
        t_cmd               cmd;
        logic [WHEEL_W-1:0] wheel;
        int                 hold_off;
        logic               idle_only;
    } t_step;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    t_cmd               cmd_drv   = '0;
    logic               cfg_we    = 1'b0;
    logic [WHEEL_W-1:0] cfg_wdata = '0;
    logic               res_valid;
    t_result            res;

    t_step   cmd_backlog[$];
    t_result awaited_results[$];
    logic    beat_taken   = 1'b0;
    int      quiet_cycles = 0;
    int      gap_left     = 0;
    logic    gap_idle     = 1'b0;
    int      errors       = 0;

    // Shadow of the timer table, updated on every accepted beat.
    logic               tt_valid     [TIMER_ENTRIES];
    logic [ID_W-1:0]    tt_id        [TIMER_ENTRIES];
    logic [WHEEL_W-1:0] tt_span      [TIMER_ENTRIES];
    logic [WHEEL_W-1:0] tt_left      [TIMER_ENTRIES];
    logic               tt_cancelled [TIMER_ENTRIES];
    logic [WHEEL_W-1:0] tt_wheel = WHEEL_W'(WHEEL_RESET);

    logic [ID_W-1:0] id_pool [POOL_SIZE];

    int n_beats = 0, n_fired = 0, n_quiet = 0, n_full = 0, n_dup = 0, n_missing = 0;
    int n_wheels = 0;

    timing_wheel_timer_table u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd_drv),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic advance_timer_table(input t_cmd c);
        t_result r;
        int      slot;
        int      free_slot;
        int      fired;
        int      eff;
        int      span;
        slot      = -1;
        free_slot = -1;
        fired     = 0;
        n_beats++;
        if (c.action == ACT_TICK) begin
            for (int i = 0; i < TIMER_ENTRIES; i++) begin
                if (tt_valid[i]) begin
                    if (tt_left[i] != 0) tt_left[i] = tt_left[i] - 1'b1;
                    if (tt_left[i] == 0) begin
                        if (!tt_cancelled[i]) begin
                            r.kind     = KIND_FIRED;
                            r.status   = ST_OK;
                            r.fired_id = tt_id[i];
                            r.last     = 1'b0;
                            awaited_results.insert(awaited_results.size(), r);
                            fired++;
                        end
                        tt_valid[i] = 1'b0;
                    end
                end
            end
            if (fired == 0) begin
                r.kind     = KIND_QUIET;
                r.status   = ST_OK;
                r.fired_id = '0;
                r.last     = 1'b1;
                awaited_results.insert(awaited_results.size(), r);
                n_quiet++;
            end else begin
                awaited_results[awaited_results.size() - 1].last = 1'b1;
                n_fired += fired;
            end
            return;
        end

        for (int i = 0; i < TIMER_ENTRIES; i++) begin
            if (tt_valid[i] && tt_id[i] == c.timer_id && slot < 0) slot = i;
            if (!tt_valid[i] && free_slot < 0) free_slot = i;
        end
        r.kind     = KIND_ACK;
        r.status   = ST_OK;
        r.fired_id = c.timer_id;
        r.last     = 1'b1;
        if (c.action == ACT_ADD) begin
            eff  = (tt_wheel == 0) ? 1 : ((tt_wheel > MAX_WHEEL) ? MAX_WHEEL : int'(tt_wheel));
            span = int'(c.delay) % eff;
            if (span == 0) span = eff;
            if (slot >= 0) begin
                r.status = ST_DUPLICATE;
                n_dup++;
            end else if (free_slot < 0) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                tt_valid[free_slot]     = 1'b1;
                tt_id[free_slot]        = c.timer_id;
                tt_span[free_slot]      = WHEEL_W'(span);
                tt_left[free_slot]      = WHEEL_W'(span);
                tt_cancelled[free_slot] = 1'b0;
            end
        end else if (slot < 0) begin
            r.status = ST_NOT_FOUND;
            n_missing++;
        end else if (c.action == ACT_REFRESH) begin
            tt_left[slot] = tt_span[slot];
        end else begin
            tt_cancelled[slot] = 1'b1;
        end
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic queue_cmd(input t_action act, input logic [ID_W-1:0] id,
                             input logic [DELAY_W-1:0] dly, input int hold,
                             input logic idle_only);
        t_step s;
        s.kind            = STEP_COMMAND;
        s.cmd.action      = act;
        s.cmd.timer_id    = id;
        s.cmd.delay       = dly;
        s.wheel           = '0;
        s.hold_off        = hold;
        s.idle_only       = idle_only;
        cmd_backlog.insert(cmd_backlog.size(), s);
    endtask

    task automatic queue_wheel(input logic [WHEEL_W-1:0] size);
        t_step s;
        s.kind      = STEP_SET_WHEEL;
        s.cmd       = '0;
        s.wheel     = size;
        s.hold_off  = 0;
        s.idle_only = 1'b0;
        cmd_backlog.insert(cmd_backlog.size(), s);
    endtask

    // Results are checked before the beat taken at the same edge is predicted,
    // since no result can come back in the cycle that accepts its command.
    always @(posedge clk) begin : monitor
        t_result want;
        if (rst_n) begin
            if (res_valid === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing expected: kind %0d id 0x%0h",
                           res.kind, res.fired_id);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(res.kind));
                    check_field("status", 64'(want.status), 64'(res.status));
                    check_field("fired_id", want.fired_id, res.fired_id);
                    check_field("last", 64'(want.last), 64'(res.last));
                end
            end
            if (cfg_we) tt_wheel = cfg_wdata;
            if (start && busy === 1'b0) advance_timer_table(cmd_drv);
            beat_taken <= start && busy === 1'b0;
            if (awaited_results.size() == 0 && busy === 1'b0 && !start)
                quiet_cycles <= quiet_cycles + 1;
            else
                quiet_cycles <= 0;
        end
    end

    // Each output changes once per falling edge at most.
    always @(negedge clk) begin : driver
        logic drive;
        logic we;
        drive = start;
        we    = 1'b0;
        if (rst_n) begin
            if (drive && beat_taken) drive = 1'b0;
            if (!drive) begin
                if (gap_left > 0) begin
                    if (!gap_idle || busy === 1'b0) gap_left--;
                end else if (cmd_backlog.size() != 0) begin
                    if (cmd_backlog[0].kind == STEP_COMMAND) begin
                        cmd_drv  <= cmd_backlog[0].cmd;
                        drive    = 1'b1;
                        gap_left = cmd_backlog[0].hold_off;
                        gap_idle = cmd_backlog[0].idle_only;
                        void'(cmd_backlog.pop_front());
                    end else if (quiet_cycles >= 4) begin
                        // The table is idle and every result is in.
                        we = 1'b1;
                        cfg_wdata <= cmd_backlog[0].wheel;
                        n_wheels++;
                        void'(cmd_backlog.pop_front());
                    end
                end
            end
        end
        start  <= drive;
        cfg_we <= we;
    end

    initial begin : sequencer
        logic [WHEEL_W-1:0] phase_wheel [10];
        t_action            act;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] dly;
        int                 pick;
        int                 hold;
        logic               idle_only;
        logic               fill;

        foreach (tt_valid[i]) tt_valid[i] = 1'b0;
        id_pool[0] = '0;
        id_pool[1] = '1;
        id_pool[2] = 64'h8000_0000_0000_0000;
        id_pool[3] = 64'h1;
        for (int i = 4; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};

        // Directed opening at the reset wheel size.
        queue_cmd(ACT_ADD, '0, 16'd0, 0, 1'b0);
        queue_cmd(ACT_ADD, '1, 16'hFFFF, 2, 1'b0);
        queue_cmd(ACT_ADD, '1, 16'd3, 0, 1'b0);
        queue_cmd(ACT_REFRESH, 64'h1234, 16'd0, 5, 1'b1);
        queue_cmd(ACT_CANCEL, 64'h1234, 16'd0, 0, 1'b0);
        queue_cmd(ACT_CANCEL, '0, 16'd0, 1, 1'b0);
        queue_cmd(ACT_CANCEL, '0, 16'd0, 0, 1'b0);
        queue_cmd(ACT_ADD, '0, 16'd7, 7, 1'b1);
        queue_cmd(ACT_REFRESH, '0, 16'hFFFF, 0, 1'b0);
        queue_cmd(ACT_TICK, '1, 16'hFFFF, 3, 1'b0);
        queue_cmd(ACT_ADD, 64'h8000_0000_0000_0001, 16'd60, 0, 1'b0);
        // Every timer added at a wheel size of one expires on the next tick; the cancelled one stays silent.
        queue_wheel(9'd1);
        queue_cmd(ACT_ADD, 64'hA, 16'd5, 0, 1'b0);
        queue_cmd(ACT_ADD, 64'hB, 16'hFFFF, 0, 1'b0);
        queue_cmd(ACT_ADD, 64'hC, 16'd0, 0, 1'b0);
        queue_cmd(ACT_CANCEL, 64'hB, 16'd0, 0, 1'b0);
        queue_cmd(ACT_TICK, '0, 16'd0, 4, 1'b0);
        queue_cmd(ACT_TICK, '0, 16'd0, 0, 1'b0);
        queue_cmd(ACT_REFRESH, '1, 16'd0, 0, 1'b0);
        queue_wheel(9'd0);
        queue_cmd(ACT_ADD, 64'hD, 16'd123, 6, 1'b0);
        queue_cmd(ACT_TICK, '0, 16'd0, 0, 1'b0);

        // Long wheels come last so that their timers do not clog the table early.
        phase_wheel = '{9'd2, 9'd5, 9'd3, 9'd17, 9'd1, 9'd60, 9'd4, 9'd8, 9'd257, 9'd511};
        for (int p = 0; p < 10; p++) begin
            queue_wheel(phase_wheel[p]);
            fill = (p == 9);
            for (int k = 0; k < 26; k++) begin
                pick      = $urandom_range(0, 99);
                id        = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                dly       = ($urandom_range(0, 4) == 0) ? DELAY_W'($urandom)
                                                        : DELAY_W'($urandom_range(0, 40));
                hold      = (p % 3 == 1) ? 0 : $urandom_range(0, 7);
                idle_only = 1'($urandom_range(0, 1));
                if (fill)
                    act = (pick < 85) ? ACT_ADD : ACT_TICK;
                else if (pick < 35)
                    act = ACT_ADD;
                else if (pick < 50)
                    act = ACT_REFRESH;
                else if (pick < 65)
                    act = ACT_CANCEL;
                else if (pick < 70) begin
                    act = t_action'($urandom_range(0, 3));
                    id  = {$urandom, $urandom};
                end else
                    act = ACT_TICK;
                if (act == ACT_TICK) id = {$urandom, $urandom};
                queue_cmd(act, id, dly, hold, idle_only);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start || busy !== 1'b0
               || awaited_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Ran %0d commands and ticks over %0d wheel sizes:", n_beats, n_wheels);
        $display("  %0d timers fired, %0d quiet ticks.", n_fired, n_quiet);
        $display("Refusals seen: %0d table full, %0d duplicate, %0d unknown id.",
                 n_full, n_dup, n_missing);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timed out with %0d steps queued and %0d results outstanding.",
                 cmd_backlog.size(), awaited_results.size());
        $display("testbench: errors");
        $finish;
    end

endmodule
